@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and is
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define NSU_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant check failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define NSU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define NSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/nsu_pkg.sv @@
package nsu_pkg;

  localparam int unsigned MaxSamplesDef   = 1024;
  localparam int unsigned ModeDepthDef    = 64;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CountW  = 11;
  localparam int unsigned SumW    = 35;
  localparam int unsigned SqSumW  = 57;
  localparam int unsigned StatW   = 32;
  localparam int unsigned SelW    = 3;
  localparam int unsigned AluW    = 72;
  localparam int unsigned DivW    = 48;
  localparam int unsigned RootW   = AluW / 2;
  localparam int unsigned StepW   = 6;
  localparam int unsigned NumW    = 38;

  localparam logic KindSample = 1'b0;
  localparam logic KindEnd    = 1'b1;

  typedef enum logic [SelW-1:0] {
    SEL_MEAN  = 3'd0,
    SEL_MODE  = 3'd1,
    SEL_STD   = 3'd2,
    SEL_RANGE = 3'd3,
    SEL_SKEW  = 3'd4
  } stat_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CLOSE,
    ST_MUL,
    ST_MUL_SS,
    ST_DIFF,
    ST_DIFF2,
    ST_SQRT,
    ST_ROOT,
    ST_MODE_RD,
    ST_MODE_CMP,
    ST_MODE_DONE,
    ST_NUM,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } nsu_state_e;

  typedef struct packed {
    logic                      kind;
    logic signed [SampleW-1:0] sample_value;
  } nsu_item_t;

  typedef struct packed {
    logic signed [StatW-1:0] stat_value;
    logic                    stat_valid;
    logic                    table_overflow;
  } nsu_result_t;

  // Saturates a sign and magnitude pair to a signed 32-bit value.
  function automatic logic [StatW-1:0] sat32(input logic neg, input logic [DivW-1:0] m);
    logic [DivW-1:0] lim_neg;
    logic [DivW-1:0] lim_pos;
    logic [StatW-1:0] r;
    lim_neg = DivW'(64'h8000_0000);
    lim_pos = DivW'(64'h7FFF_FFFF);
    if (neg) begin
      r = (m > lim_neg) ? 32'h8000_0000 : (32'd0 - m[StatW-1:0]);
    end else begin
      r = (m > lim_pos) ? 32'h7FFF_FFFF : m[StatW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/nsu_ram.sv @@
module nsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/neighborhood_statistic_unit.sv @@
// Neighbourhood statistic unit. A transaction is taken when start is high and
// busy is low; a sample transaction keeps busy high while the mode table is
// searched entry by entry through its single read port, ending early when the
// value is found. A closing transaction emits exactly one result on res_o,
// marked by done_o for a single cycle; the receiver cannot stall it, so res_o
// must be captured on that cycle. Range and an empty set emit directly, mean
// uses a 48-step division, mode scans every table entry, and std uses two
// shift-add multiplies, a 36-step square root and a 48-step division on one
// shared 72-bit adder; skew adds a mode scan and a further multiply. The state
// is cleared when the result is emitted.
`include "assert_macros.svh"

module neighborhood_statistic_unit import nsu_pkg::*; #(
  parameter int unsigned MaxSamples    = MaxSamplesDef,
  parameter int unsigned ModeTableDepth = ModeDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  nsu_item_t       item_i,
  input  logic            cfg_we_i,
  input  logic [SelW-1:0] cfg_wdata_i,
  output logic            done_o,
  output nsu_result_t     res_o
);

  localparam int unsigned AW     = (ModeTableDepth > 1) ? $clog2(ModeTableDepth) : 1;
  localparam int unsigned KW     = $clog2(ModeTableDepth + 1);
  localparam int unsigned EntryW = SampleW + CountW;
  localparam int unsigned SqW    = 2 * SampleW;

  nsu_state_e state_q, state_d, ret_q, ret_d;

  logic [SelW-1:0]           sel_q;
  logic [CountW-1:0]         cnt_q, cnt_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic [SqSumW-1:0]         sq_q, sq_d;
  logic signed [SampleW-1:0] min_q, min_d, max_q, max_d, v_q, v_d, key_q, key_d;
  logic [KW-1:0]             keys_q, keys_d, idx_q, idx_d;
  logic                      ovf_q, ovf_d;
  logic [SqW-1:0]            vsq_q, vsq_d;
  logic [AluW-1:0]           acc_q, acc_d, mcand_q, mcand_d, a_q, a_d;
  logic [AluW-1:0]           rem_q, rem_d, dvs_q, dvs_d;
  logic [SumW-1:0]           mplier_q, mplier_d;
  logic [RootW-1:0]          root_q, root_d;
  logic [StepW-1:0]          step_q, step_d;
  logic [DivW-1:0]           dvd_q, dvd_d;
  logic [CountW-1:0]         best_q, best_d;
  logic                      neg_q, neg_d;
  nsu_result_t               res_q, res_d;
  logic                      done_q, done_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [EntryW-1:0]         ram_wdata, ram_rdata;
  logic signed [SampleW-1:0] rd_key;
  logic [CountW-1:0]         rd_cnt;

  logic [AluW-1:0]           alu_a, alu_b;
  logic                      alu_sub;
  logic [AluW:0]             alu_sum;
  logic                      alu_carry;

  logic [SumW-1:0]           sum_mag;
  logic [SampleW-1:0]        v_mag, key_mag;
  logic [AluW-1:0]           rem_sq, rem_dv, trial;
  logic                      idx_last;
  logic signed [NumW-1:0]    prod_s, num;
  logic [NumW-1:0]           num_mag;
  logic                      mode_better;

  nsu_ram #(
    .Width(EntryW),
    .Depth(ModeTableDepth)
  ) u_mode_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_key    = ram_rdata[EntryW-1:CountW];
  assign rd_cnt    = ram_rdata[CountW-1:0];
  assign sum_mag   = sum_q[SumW-1] ? (SumW'(0) - sum_q) : sum_q;
  assign v_mag     = v_q[SampleW-1] ? (SampleW'(0) - v_q) : v_q;
  assign key_mag   = key_q[SampleW-1] ? (SampleW'(0) - key_q) : key_q;
  assign rem_sq    = {rem_q[AluW-3:0], acc_q[AluW-1 -: 2]};
  assign rem_dv    = {rem_q[AluW-2:0], dvd_q[DivW-1]};
  assign trial     = AluW'({root_q, 2'b01});
  assign idx_last  = (KW'(idx_q + KW'(1)) == keys_q);
  assign mode_better = (rd_cnt > best_q) || ((rd_cnt == best_q) && (rd_key < key_q));

  // The product of n and the mode magnitude fits well inside NumW bits.
  assign prod_s  = key_q[SampleW-1] ? (NumW'(0) - $signed(NumW'(acc_q[NumW-2:0])))
                                    : $signed(NumW'(acc_q[NumW-2:0]));
  assign num     = NumW'(sum_q) - prod_s;
  assign num_mag = num[NumW-1] ? (NumW'(0) - num) : num;

  // Shared adder: multiply accumulate, difference, square root and division steps.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_MUL: begin
        alu_a = acc_q;
        alu_b = mcand_q;
      end
      ST_DIFF: begin
        alu_a   = a_q;
        alu_b   = acc_q;
        alu_sub = 1'b1;
      end
      ST_DIFF2: begin
        alu_a   = acc_q;
        alu_b   = a_q;
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = rem_sq;
        alu_b   = trial;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = rem_dv;
        alu_b   = dvs_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AluW+1)'(alu_sub);
  assign alu_carry = alu_sum[AluW];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (item_i.kind == KindSample) ? ST_SQUARE : ST_CLOSE;
        end
      end
      ST_SQUARE: begin
        state_d = (cnt_q >= CountW'(MaxSamples)) ? ST_IDLE : ST_UPDATE;
      end
      ST_UPDATE:   state_d = ST_SRCH_RD;
      ST_SRCH_RD:  state_d = (idx_q == keys_q) ? ST_IDLE : ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = (rd_key == v_q) ? ST_IDLE : ST_SRCH_RD;
      ST_CLOSE: begin
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          case (stat_sel_e'(sel_q))
            SEL_MEAN:           state_d = ST_DIV;
            SEL_MODE:           state_d = ST_MODE_RD;
            SEL_STD, SEL_SKEW:  state_d = ST_MUL;
            default:            state_d = ST_EMIT;
          endcase
        end
      end
      ST_MUL:       state_d = (mplier_q == '0) ? ret_q : ST_MUL;
      ST_MUL_SS:    state_d = ST_MUL;
      ST_DIFF:      state_d = alu_carry ? ST_SQRT : ST_DIFF2;
      ST_DIFF2:     state_d = ST_SQRT;
      ST_SQRT:      state_d = (step_q == '0) ? ST_ROOT : ST_SQRT;
      ST_ROOT: begin
        if (stat_sel_e'(sel_q) == SEL_STD) begin
          state_d = ST_DIV;
        end else begin
          state_d = (root_q == '0) ? ST_EMIT : ST_MODE_RD;
        end
      end
      ST_MODE_RD:   state_d = ST_MODE_CMP;
      ST_MODE_CMP:  state_d = idx_last ? ST_MODE_DONE : ST_MODE_RD;
      ST_MODE_DONE: state_d = (stat_sel_e'(sel_q) == SEL_MODE) ? ST_EMIT : ST_MUL;
      ST_NUM:       state_d = ST_DIV;
      ST_DIV:       state_d = (step_q == '0) ? ST_FINISH : ST_DIV;
      ST_FINISH:    state_d = ST_EMIT;
      ST_EMIT:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    min_d    = min_q;
    max_d    = max_q;
    keys_d   = keys_q;
    ovf_d    = ovf_q;
    v_d      = v_q;
    vsq_d    = vsq_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    a_d      = a_q;
    rem_d    = rem_q;
    root_d   = root_q;
    step_d   = step_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    best_d   = best_q;
    key_d    = key_q;
    neg_d    = neg_q;
    ret_d    = ret_q;
    res_d    = res_q;
    done_d   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = keys_q[AW-1:0];
    ram_wdata = {v_q, CountW'(1)};
    case (state_q)
      ST_IDLE: begin
        v_d = item_i.sample_value;
      end
      ST_SQUARE: begin
        vsq_d = SqW'(v_mag) * SqW'(v_mag);
      end
      ST_UPDATE: begin
        cnt_d = cnt_q + CountW'(1);
        sum_d = sum_q + SumW'(v_q);
        sq_d  = sq_q + SqSumW'(vsq_q);
        if (cnt_q == '0 || v_q < min_q) begin
          min_d = v_q;
        end
        if (cnt_q == '0 || v_q > max_q) begin
          max_d = v_q;
        end
        idx_d = '0;
      end
      ST_SRCH_RD: begin
        if (idx_q == keys_q) begin
          if (keys_q < KW'(ModeTableDepth)) begin
            ram_we = 1'b1;
            keys_d = keys_q + KW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_SRCH_CMP: begin
        if (rd_key == v_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = {rd_key, rd_cnt + CountW'(1)};
        end else begin
          idx_d = idx_q + KW'(1);
        end
      end
      ST_CLOSE: begin
        res_d = '0;
        if (cnt_q != '0) begin
          res_d.table_overflow = ovf_q;
          case (stat_sel_e'(sel_q))
            SEL_MEAN: begin
              dvd_d  = DivW'({sum_mag, 1'b0}) + DivW'(cnt_q);
              dvs_d  = AluW'({cnt_q, 1'b0});
              rem_d  = '0;
              step_d = StepW'(DivW);
            end
            SEL_MODE: begin
              idx_d  = '0;
              best_d = '0;
              key_d  = '0;
            end
            SEL_STD, SEL_SKEW: begin
              acc_d    = '0;
              mcand_d  = AluW'(sq_q);
              mplier_d = SumW'(cnt_q);
              ret_d    = ST_MUL_SS;
            end
            SEL_RANGE: begin
              res_d.stat_value = StatW'(max_q) - StatW'(min_q);
              res_d.stat_valid = 1'b1;
            end
            default: begin
              res_d.stat_valid = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) begin
            acc_d = alu_sum[AluW-1:0];
          end
          mcand_d  = {mcand_q[AluW-2:0], 1'b0};
          mplier_d = mplier_q >> 1;
        end
      end
      ST_MUL_SS: begin
        a_d      = acc_q;
        acc_d    = '0;
        mcand_d  = AluW'(sum_mag);
        mplier_d = sum_mag;
        ret_d    = ST_DIFF;
      end
      ST_DIFF, ST_DIFF2: begin
        if (alu_carry || state_q == ST_DIFF2) begin
          acc_d  = alu_sum[AluW-1:0];
          rem_d  = '0;
          root_d = '0;
          step_d = StepW'(RootW);
        end
      end
      ST_SQRT: begin
        if (step_q != '0) begin
          if (alu_carry) begin
            rem_d  = alu_sum[AluW-1:0];
            root_d = {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_d  = rem_sq;
            root_d = {root_q[RootW-2:0], 1'b0};
          end
          acc_d  = {acc_q[AluW-3:0], 2'b00};
          step_d = step_q - StepW'(1);
        end
      end
      ST_ROOT: begin
        if (stat_sel_e'(sel_q) == SEL_STD) begin
          dvd_d  = DivW'({root_q, 1'b0}) + DivW'(cnt_q);
          dvs_d  = AluW'({cnt_q, 1'b0});
          rem_d  = '0;
          step_d = StepW'(DivW);
        end else begin
          idx_d  = '0;
          best_d = '0;
          key_d  = '0;
        end
      end
      ST_MODE_CMP: begin
        if (mode_better) begin
          best_d = rd_cnt;
          key_d  = rd_key;
        end
        if (!idx_last) begin
          idx_d = idx_q + KW'(1);
        end
      end
      ST_MODE_DONE: begin
        res_d.stat_value = StatW'(key_q);
        res_d.stat_valid = 1'b1;
        acc_d    = '0;
        mcand_d  = AluW'(key_mag);
        mplier_d = SumW'(cnt_q);
        ret_d    = ST_NUM;
      end
      ST_NUM: begin
        // Numerator scaled by 256, doubled, plus the root for round to nearest.
        neg_d  = num[NumW-1];
        dvd_d  = DivW'({num_mag, 9'b0}) + DivW'(root_q);
        dvs_d  = AluW'({root_q, 1'b0});
        rem_d  = '0;
        step_d = StepW'(DivW);
      end
      ST_DIV: begin
        if (step_q != '0) begin
          if (alu_carry) begin
            rem_d = alu_sum[AluW-1:0];
          end else begin
            rem_d = rem_dv;
          end
          dvd_d  = {dvd_q[DivW-2:0], alu_carry};
          step_d = step_q - StepW'(1);
        end
      end
      ST_FINISH: begin
        res_d.stat_valid = 1'b1;
        case (stat_sel_e'(sel_q))
          SEL_MEAN: res_d.stat_value = sat32(sum_q[SumW-1], dvd_q);
          SEL_SKEW: res_d.stat_value = sat32(neg_q, dvd_q);
          default:  res_d.stat_value = sat32(1'b0, dvd_q);
        endcase
      end
      ST_EMIT: begin
        done_d = 1'b1;
        cnt_d  = '0;
        sum_d  = '0;
        sq_d   = '0;
        min_d  = '0;
        max_d  = '0;
        keys_d = '0;
        ovf_d  = 1'b0;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      sel_q   <= SEL_MEAN;
      cnt_q   <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      min_q   <= '0;
      max_q   <= '0;
      keys_q  <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
      mplier_q <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      min_q   <= min_d;
      max_q   <= max_d;
      keys_q  <= keys_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      mplier_q <= mplier_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    vsq_q   <= vsq_d;
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    a_q     <= a_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    best_q  <= best_d;
    key_q   <= key_d;
    neg_q   <= neg_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `NSU_ASSERT(a_keys_bound, keys_q <= KW'(ModeTableDepth))
  `NSU_ASSERT_IMPLY(a_done_idle, done_o, !busy)
  `NSU_ASSERT_IMPLY(a_cleared_on_done, done_o, cnt_q == '0 && keys_q == '0 && !ovf_q)
  `NSU_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule
